>>> rtl/isim_pkg.sv
// Shared types and constants for the interval set insert/merge block.
package isim_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int LANES    = 4;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [ADDR_W-1:0]  t_addr;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } t_status;

    typedef struct packed {
        t_op        operation;
        t_addr      start_addr;
        t_addr      end_addr;
        logic [3:0] entry_index;
    } t_in_item;

    typedef struct packed {
        t_addr   entry_start;
        t_addr   entry_end;
        logic    entry_valid;
        t_count  interval_count;
        t_addr   covered_size;
        t_status status;
    } t_out_item;

    typedef struct packed {
        t_addr start_v;
        t_addr end_v;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_ADD  = 2'd1,
        ACC_SUB  = 2'd2
    } t_acc_op;

    typedef struct packed {
        t_acc_op op;
        t_addr   lo;
        t_addr   hi;
    } t_acc_req;

    typedef struct packed {
        logic [LANES-1:0][ADDR_W-1:0] a;
        logic [LANES-1:0][ADDR_W-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic [LANES-1:0] lt;
    } t_cmp_rsp;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_GROW  = 7'b0000100,
        S_MERGE = 7'b0001000,
        S_PACK  = 7'b0010000,
        S_READ  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

endpackage

>>> rtl/isim_ram.sv
// Generic single-write, single-read RAM with registered read data.
module isim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/isim_cmp.sv
// Shared unsigned compare unit: four independent less-than lanes.
module isim_cmp (
    input  isim_pkg::t_cmp_req i_req,
    output isim_pkg::t_cmp_rsp o_rsp
);

    always_comb begin
        for (int k = 0; k < isim_pkg::LANES; k++) begin
            o_rsp.lt[k] = i_req.a[k] < i_req.b[k];
        end
    end

endmodule

>>> rtl/isim_acc.sv
// Covered-size accumulator: running sums of starts and ends, one update a cycle.
module isim_acc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isim_pkg::t_acc_req i_req,
    output isim_pkg::t_addr    o_covered
);

    isim_pkg::t_addr r_sum_lo, n_sum_lo;
    isim_pkg::t_addr r_sum_hi, n_sum_hi;

    always_comb begin
        n_sum_lo = r_sum_lo;
        n_sum_hi = r_sum_hi;
        unique case (i_req.op)
            isim_pkg::ACC_ADD: begin
                n_sum_lo = r_sum_lo + i_req.lo;
                n_sum_hi = r_sum_hi + i_req.hi;
            end
            isim_pkg::ACC_SUB: begin
                n_sum_lo = r_sum_lo - i_req.lo;
                n_sum_hi = r_sum_hi - i_req.hi;
            end
            default: begin
                n_sum_lo = r_sum_lo;
                n_sum_hi = r_sum_hi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_lo <= '0;
            r_sum_hi <= '0;
        end else begin
            r_sum_lo <= n_sum_lo;
            r_sum_hi <= n_sum_hi;
        end
    end

    // sum of (end - start) modulo 2^32
    assign o_covered = r_sum_hi - r_sum_lo;

endmodule

>>> rtl/interval_set_insert_merge_top.sv
// Interval set top level: sequencer over the entry RAM, compare unit and accumulator.
//
// Keeps up to CAPACITY (16) disjoint [start, end] intervals sorted by start in a
// RAM that moves one entry per cycle. A read item passes through S_READ, which
// captures the addressed entry, and S_FIN, which loads the output register. An
// insert first scans entries from index 0 until it finds its place, then either
// shifts the entries above up by one or absorbs the run of overlapping or touching
// entries and moves the tail down. An insert that would add an entry to a full
// table is dropped. A rejected insert (start above end) goes straight to S_FIN.
// The block takes one item at a time; a finished result waits in the output
// register while the next item is accepted, and a result still held there stalls
// the sequencer in its last step. Reset empties the set.
module interval_set_insert_merge_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  isim_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output isim_pkg::t_out_item o_out_item
);

    isim_pkg::t_state    r_state, n_state;
    isim_pkg::t_cnt      r_cnt, n_cnt;
    isim_pkg::t_cnt      r_ptr, n_ptr;
    isim_pkg::t_cnt      r_i, n_i;
    isim_pkg::t_cnt      r_j, n_j;
    isim_pkg::t_cnt      r_k, n_k;
    isim_pkg::t_cnt      r_rem, n_rem;
    isim_pkg::t_addr     r_s, n_s;
    isim_pkg::t_addr     r_e, n_e;
    logic [3:0]          r_idx, n_idx;
    isim_pkg::t_addr     r_ns, n_ns;
    isim_pkg::t_addr     r_ne, n_ne;
    isim_pkg::t_addr     r_rs, n_rs;
    isim_pkg::t_addr     r_re, n_re;
    logic                r_rv, n_rv;
    isim_pkg::t_status   r_st, n_st;
    logic                r_ovalid, n_ovalid;
    isim_pkg::t_out_item r_out, n_out;

    logic                ram_we;
    isim_pkg::t_idx      ram_waddr;
    isim_pkg::t_entry    ram_wdata;
    isim_pkg::t_idx      ram_raddr;
    logic [isim_pkg::ENTRY_W-1:0] ram_rdata;
    isim_pkg::t_entry    q;

    isim_pkg::t_cmp_req  cmp_req;
    isim_pkg::t_cmp_rsp  cmp_rsp;
    isim_pkg::t_acc_req  acc_req;
    isim_pkg::t_addr     covered;

    logic                in_acc;
    logic                have;
    isim_pkg::t_cnt      rem;

    isim_ram #(
        .WIDTH(isim_pkg::ENTRY_W),
        .DEPTH(isim_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign q = isim_pkg::t_entry'(ram_rdata);

    isim_cmp u_cmp (
        .i_req (cmp_req),
        .o_rsp (cmp_rsp)
    );

    isim_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (acc_req),
        .o_covered (covered)
    );

    assign o_in_ready  = (r_state == isim_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_rem    = r_rem;
        n_s      = r_s;
        n_e      = r_e;
        n_idx    = r_idx;
        n_ns     = r_ns;
        n_ne     = r_ne;
        n_rs     = r_rs;
        n_re     = r_re;
        n_rv     = r_rv;
        n_st     = r_st;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;

        ram_we    = 1'b0;
        ram_waddr = isim_pkg::t_idx'(r_i);
        ram_wdata = q;
        ram_raddr = isim_pkg::t_idx'(r_ptr + 1'b1);

        acc_req.op = isim_pkg::ACC_HOLD;
        acc_req.lo = q.start_v;
        acc_req.hi = q.end_v;

        // scan lanes: end<s, e<start, start<s, e<end
        cmp_req.a[0] = q.end_v;   cmp_req.b[0] = r_s;
        cmp_req.a[1] = r_e;       cmp_req.b[1] = q.start_v;
        cmp_req.a[2] = q.start_v; cmp_req.b[2] = r_s;
        cmp_req.a[3] = r_e;       cmp_req.b[3] = q.end_v;

        have = 1'b0;
        rem  = r_j - r_i - 1'b1;

        unique case (r_state)
            isim_pkg::S_IDLE: begin
                cmp_req.a[0] = i_in_item.end_addr;
                cmp_req.b[0] = i_in_item.start_addr;
                ram_raddr = (i_in_item.operation == isim_pkg::OP_READ)
                          ? isim_pkg::t_idx'(i_in_item.entry_index) : '0;
                if (in_acc) begin
                    n_s   = i_in_item.start_addr;
                    n_e   = i_in_item.end_addr;
                    n_idx = i_in_item.entry_index;
                    n_rs  = '0;
                    n_re  = '0;
                    n_rv  = 1'b0;
                    n_st  = isim_pkg::ST_OK;
                    n_ptr = '0;
                    if (i_in_item.operation == isim_pkg::OP_READ) begin
                        n_state = isim_pkg::S_READ;
                    end else if (cmp_rsp.lt[0]) begin
                        n_st    = isim_pkg::ST_ORDER;
                        n_state = isim_pkg::S_FIN;
                    end else begin
                        n_state = isim_pkg::S_SCAN;
                    end
                end
            end
            isim_pkg::S_READ: begin
                if (32'(r_idx) < 32'(r_cnt)) begin
                    n_rs = q.start_v;
                    n_re = q.end_v;
                    n_rv = 1'b1;
                end
                n_state = isim_pkg::S_FIN;
            end
            isim_pkg::S_SCAN: begin
                have = r_ptr < r_cnt;
                if (have && cmp_rsp.lt[0]) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    n_i = r_ptr;
                    if (!have || cmp_rsp.lt[1]) begin
                        if (r_cnt == isim_pkg::t_cnt'(isim_pkg::CAPACITY)) begin
                            n_st    = isim_pkg::ST_FULL;
                            n_state = isim_pkg::S_FIN;
                        end else begin
                            acc_req.op = isim_pkg::ACC_ADD;
                            acc_req.lo = r_s;
                            acc_req.hi = r_e;
                            n_k        = r_cnt;
                            ram_raddr  = isim_pkg::t_idx'(r_cnt - 1'b1);
                            n_state    = isim_pkg::S_GROW;
                        end
                    end else begin
                        n_ns       = cmp_rsp.lt[2] ? q.start_v : r_s;
                        n_ne       = cmp_rsp.lt[3] ? q.end_v : r_e;
                        acc_req.op = isim_pkg::ACC_SUB;
                        n_j        = r_ptr + 1'b1;
                        n_state    = isim_pkg::S_MERGE;
                    end
                end
            end
            isim_pkg::S_GROW: begin
                ram_we = 1'b1;
                if (r_k == r_i) begin
                    ram_waddr = isim_pkg::t_idx'(r_i);
                    ram_wdata = '{start_v: r_s, end_v: r_e};
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = isim_pkg::S_FIN;
                end else begin
                    ram_waddr = isim_pkg::t_idx'(r_k);
                    ram_wdata = q;
                    ram_raddr = isim_pkg::t_idx'(r_k - 2'd2);
                    n_k       = r_k - 1'b1;
                end
            end
            isim_pkg::S_MERGE: begin
                // lanes: ne<start (gap), ne<end (extend)
                cmp_req.a[0] = r_ne; cmp_req.b[0] = q.start_v;
                cmp_req.a[1] = r_ne; cmp_req.b[1] = q.end_v;
                ram_raddr = isim_pkg::t_idx'(r_j + 1'b1);
                have = r_j < r_cnt;
                if (have && !cmp_rsp.lt[0]) begin
                    if (cmp_rsp.lt[1]) begin
                        n_ne = q.end_v;
                    end
                    acc_req.op = isim_pkg::ACC_SUB;
                    n_j        = r_j + 1'b1;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = isim_pkg::t_idx'(r_i);
                    ram_wdata  = '{start_v: r_ns, end_v: r_ne};
                    acc_req.op = isim_pkg::ACC_ADD;
                    acc_req.lo = r_ns;
                    acc_req.hi = r_ne;
                    n_rem      = rem;
                    if (rem == '0) begin
                        n_state = isim_pkg::S_FIN;
                    end else begin
                        ram_raddr = isim_pkg::t_idx'(r_j);
                        n_k       = r_j;
                        n_state   = isim_pkg::S_PACK;
                    end
                end
            end
            isim_pkg::S_PACK: begin
                have = r_k < r_cnt;
                ram_raddr = isim_pkg::t_idx'(r_k + 1'b1);
                if (have) begin
                    ram_we    = 1'b1;
                    ram_waddr = isim_pkg::t_idx'(r_k - r_rem);
                    ram_wdata = q;
                    n_k       = r_k + 1'b1;
                end else begin
                    n_cnt   = r_cnt - r_rem;
                    n_state = isim_pkg::S_FIN;
                end
            end
            isim_pkg::S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out.entry_start    = r_rs;
                    n_out.entry_end      = r_re;
                    n_out.entry_valid    = r_rv;
                    n_out.interval_count = isim_pkg::t_count'(r_cnt);
                    n_out.covered_size   = covered;
                    n_out.status         = r_st;
                    n_ovalid             = 1'b1;
                    n_state              = isim_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isim_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= isim_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_rem <= n_rem;
        r_s   <= n_s;
        r_e   <= n_e;
        r_idx <= n_idx;
        r_ns  <= n_ns;
        r_ne  <= n_ne;
        r_rs  <= n_rs;
        r_re  <= n_re;
        r_rv  <= n_rv;
        r_st  <= n_st;
        r_out <= n_out;
    end

endmodule
